// ===== src/bba_pkg.sv =====
// Package for the bitmap block allocator: sizes, command codes, payload types,
// controller state and the command/status structs between controller and datapath.
// No dependencies.
package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int INDEX_SPAN = 4096;
    localparam int INDEX_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    // blocks that can actually be tracked: limited by storage and by the index field
    localparam int CAP        = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;
    localparam int MAP_WORDS  = (CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FULLW_W    = COUNT_W - BIT_W;

    localparam logic [COUNT_W-1:0] CAP_COUNT     = COUNT_W'(CAP);
    localparam logic [COUNT_W-1:0] TRACKED_RESET = COUNT_W'(4096);

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_TRACKED = 1'b0;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_MARK    = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [INDEX_W-1:0] block_index;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] granted_index;
        logic               occupied;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_START,
        ST_SCAN,
        ST_READ,
        ST_MODIFY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic alloc_start;
        logic scan;
        logic rmw_read;
        logic rmw_modify;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t command;
        logic count_zero;
        logic hit;
        logic last_word;
        logic out_full;
    } dp_status_t;

endpackage

// ===== src/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bba_regs.sv =====
// APB register file: holds tracked_count and derives the effective block count.
// Depends on bba_pkg.
module bba_regs
    import bba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic [COUNT_W-1:0]    eff_count
);

    logic [COUNT_W-1:0] tracked_reg;
    logic [COUNT_W-1:0] tracked_next;
    logic               wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_TRACKED);

    always_comb
    begin
        tracked_next = tracked_reg;
        if (wr_en)
        begin
            tracked_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg <= TRACKED_RESET;
        end
        else
        begin
            tracked_reg <= tracked_next;
        end
    end

    assign prdata    = (paddr[2] == REG_TRACKED) ? APB_DATA_W'(tracked_reg) : '0;
    assign eff_count = (tracked_reg > CAP_COUNT) ? CAP_COUNT : tracked_reg;

endmodule

// ===== src/bba_ctrl.sv =====
// Controller state machine for the allocator: sequences accept, word scan,
// read-modify-write and result hand-off. Depends on bba_pkg.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (status.command == CMD_ALLOC) ? ST_ALLOC_START : ST_READ;
                end
            end
            ST_ALLOC_START:
            begin
                state_next = status.count_zero ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.hit || status.last_word)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:   state_next = ST_MODIFY;
            ST_MODIFY: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            ST_ALLOC_START: cmd.alloc_start = 1'b1;
            ST_SCAN:        cmd.scan        = 1'b1;
            ST_READ:        cmd.rmw_read    = 1'b1;
            ST_MODIFY:      cmd.rmw_modify  = 1'b1;
            ST_FINISH:      cmd.load_out    = !status.out_full;
            default:        cmd             = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/bba_dp.sv =====
// Datapath for the allocator: occupancy map RAM with per-word valid bits,
// word scan with first-free search, read-modify-write and output register.
// Depends on bba_pkg and bba_ram.
module bba_dp
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  in_item_t           in_data,
    input  logic [COUNT_W-1:0] eff_count,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    cmd_t                 cmd_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [WORD_AW-1:0]   ptr_reg;
    logic [WORD_AW-1:0]   ptr_next;
    out_item_t            res_reg;
    out_item_t            res_next;
    out_item_t            out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [MAP_WORDS-1:0] wvalid_reg;
    logic                 rvalid_reg;

    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     hit_bit;
    logic                 hit;
    logic [FULLW_W-1:0]   ptr_ext;
    logic [COUNT_W-1:0]   last_pos;
    logic                 last_word;
    logic [WORD_AW-1:0]   idx_word;
    logic [WORD_BITS-1:0] idx_mask;
    logic                 idx_in_range;

    bba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // words never written since reset read as all free
    assign cur_word = rvalid_reg ? ram_rdata : '0;

    assign ptr_ext  = FULLW_W'(ptr_reg);
    assign last_pos = eff_count - COUNT_W'(1);
    assign last_word = (eff_count != '0) && (ptr_ext == last_pos[COUNT_W-1:BIT_W]);

    always_comb
    begin
        if (ptr_ext < eff_count[COUNT_W-1:BIT_W])
        begin
            range_mask = '1;
        end
        else if (ptr_ext == eff_count[COUNT_W-1:BIT_W])
        begin
            range_mask = (WORD_BITS'(1) << eff_count[BIT_W-1:0]) - WORD_BITS'(1);
        end
        else
        begin
            range_mask = '0;
        end
    end

    assign free_bits = ~cur_word & range_mask;
    assign hit       = |free_bits;

    always_comb
    begin
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign idx_word     = idx_reg[BIT_W +: WORD_AW];
    assign idx_mask     = WORD_BITS'(1) << idx_reg[BIT_W-1:0];
    assign idx_in_range = (COUNT_W'(idx_reg) < eff_count);

    always_comb
    begin
        if (cmd.alloc_start)
        begin
            ram_raddr = '0;
        end
        else if (cmd.scan)
        begin
            ram_raddr = last_word ? ptr_reg : ptr_reg + WORD_AW'(1);
        end
        else if (cmd.rmw_read)
        begin
            ram_raddr = idx_word;
        end
        else
        begin
            ram_raddr = ptr_reg;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_word;
        ram_wdata = cur_word;
        ptr_next  = ptr_reg;
        res_next  = res_reg;
        if (cmd.alloc_start)
        begin
            ptr_next = '0;
            res_next = '0;
        end
        else if (cmd.scan)
        begin
            if (hit)
            begin
                ram_we                 = 1'b1;
                ram_waddr              = ptr_reg;
                ram_wdata              = cur_word | (WORD_BITS'(1) << hit_bit);
                res_next.found         = 1'b1;
                res_next.granted_index = INDEX_W'({ptr_reg, hit_bit});
                res_next.occupied      = 1'b0;
            end
            else if (!last_word)
            begin
                ptr_next = ptr_reg + WORD_AW'(1);
            end
        end
        else if (cmd.rmw_modify)
        begin
            res_next = '0;
            case (cmd_reg)
                CMD_RELEASE:
                begin
                    ram_we    = idx_in_range;
                    ram_wdata = cur_word & ~idx_mask;
                end
                CMD_MARK:
                begin
                    ram_we    = idx_in_range;
                    ram_wdata = cur_word | idx_mask;
                end
                CMD_QUERY:
                begin
                    res_next.occupied = !idx_in_range || ((cur_word & idx_mask) != '0);
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            wvalid_reg    <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rvalid_reg    <= wvalid_reg[ram_raddr];
            if (ram_we)
            begin
                wvalid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg <= in_data.command;
            idx_reg <= in_data.block_index;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
        ptr_reg <= ptr_next;
        res_reg <= res_next;
    end

    assign status.command    = cmd.latch_in ? in_data.command : cmd_reg;
    assign status.count_zero = (eff_count == '0);
    assign status.hit        = hit;
    assign status.last_word  = last_word;
    assign status.out_full   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/bitmap_block_allocator_top.sv =====
// Top level of the bitmap first-fit block allocator.
// Depends on bba_pkg, bba_regs, bba_ctrl, bba_dp (and bba_ram below it).
//
//  channel   direction  handshake                    payload
//  in        to block   in_valid / in_stall          in_item_t  (command, block_index)
//  out       from block out_valid / out_stall        out_item_t (found, granted_index, occupied)
//  apb       to block   psel/penable/pwrite, pready  tracked_count at byte address 0
//
// One transaction at a time. Release, mark and query go from accept through a RAM
// read and a modify step (a write-back for release and mark) to the finish state.
// Allocate reads one 32-bit map word per cycle, starting at word 0;
// the scan stops at the first word with a free block or at the last word in range.
// Reset clears the map at once through per-word valid bits; no clearing pass.
// A stalled output holds the block in its finish state until the previous result is taken.
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0] eff_count;
    dp_cmd_t            dp_cmd;
    dp_status_t         dp_status;

    assign pready = 1'b1;

    bba_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .eff_count(eff_count)
    );

    bba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    bba_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .eff_count(eff_count),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

// ===== src/bba_checker.sv =====
// Port-level checker for the allocator top level, bound to it below.
// Depends on bba_pkg.
module bba_checker
    import bba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted a transaction back to back");

    a_index_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.granted_index == '0)
        else $error("granted index nonzero without a grant");

    a_grant_not_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> !out_data.occupied)
        else $error("grant and occupied both set");

endmodule

bind bitmap_block_allocator_top bba_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

// ===== sim/tb_bitmap_block_allocator_top.sv =====
// Testbench for bitmap_block_allocator_top: directed and random allocate, release,
// mark and query transactions checked against an in-bench occupancy map model.
// Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_bitmap_block_allocator_top;
    import bba_pkg::*;

    localparam int MAP_SIZE = 4096;
    localparam logic [PADDR_W-1:0] ADDR_TRACKED = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_SPARE   = PADDR_W'(4);
    localparam int HOLD_CYCLES = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bitmap_block_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // model state
    bit [MAP_SIZE-1:0]  occ_map = '0;
    logic [COUNT_W-1:0] tracked_model = TRACKED_RESET;

    in_item_t  pending_cmds[$];
    out_item_t results_due[$];

    int  items_queued = 0;
    int  items_taken = 0;
    int  fail_count = 0;
    int  cmd_tally[4] = '{0, 0, 0, 0};
    int  grant_tally = 0;
    int  miss_tally = 0;
    int  config_writes = 0;

    bit  in_fired = 1'b0;
    bit  out_fired = 1'b0;
    int  in_wait = 0;
    int  out_wait = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  hold_go = 1'b0;
    bit  hold_rx = 1'b0;

    function automatic int live_blocks();
        return (int'(tracked_model) > MAP_SIZE) ? MAP_SIZE : int'(tracked_model);
    endfunction

    // applies one transaction to the model map and returns the result it must produce
    function automatic out_item_t bitmap_apply(in_item_t it);
        out_item_t r;
        int        limit;
        int        idx;
        r     = '0;
        limit = live_blocks();
        idx   = int'(it.block_index);
        cmd_tally[it.command]++;
        case (it.command)
            CMD_ALLOC:
            begin
                for (int i = 0; i < limit && !r.found; i++)
                begin
                    if (!occ_map[i])
                    begin
                        occ_map[i]      = 1'b1;
                        r.found         = 1'b1;
                        r.granted_index = INDEX_W'(i);
                    end
                end
                if (r.found)
                    grant_tally++;
                else
                    miss_tally++;
            end
            CMD_RELEASE:
            begin
                if (idx < limit)
                    occ_map[idx] = 1'b0;
            end
            CMD_MARK:
            begin
                if (idx < limit)
                    occ_map[idx] = 1'b1;
            end
            default:
            begin
                r.occupied = (idx >= limit) ? 1'b1 : occ_map[idx];
            end
        endcase
        return r;
    endfunction

    // accept side: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        in_fired  = rst_n && in_valid && !in_stall;
        out_fired = rst_n && out_valid && !out_stall;
        if (in_fired)
        begin
            results_due.push_back(bitmap_apply(in_data));
            items_taken++;
        end
        if (out_fired)
        begin
            if (results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with nothing expected: found=%0d idx=%0d occ=%0d",
                             $realtime, out_data.found, out_data.granted_index,
                             out_data.occupied);
            end
            else
            begin
                out_item_t want;
                want = results_due.pop_front();
                if (out_data.found !== want.found
                    || out_data.granted_index !== want.granted_index
                    || out_data.occupied !== want.occupied)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp found=%0d idx=%0d occ=%0d, got found=%0d idx=%0d occ=%0d",
                                 $realtime, want.found, want.granted_index, want.occupied,
                                 out_data.found, out_data.granted_index, out_data.occupied);
                end
            end
        end
    end

    // sender: a random idle gap after each transaction, quiet stretches now and then
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            if (in_wait != 0)
            begin
                in_valid <= 1'b0;
                in_wait  <= in_wait - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                if ($urandom_range(0, 39) == 0)
                    tx_quiet = !tx_quiet;
                in_data  <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                in_wait  <= tx_quiet ? 0 : $urandom_range(0, 14);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: a random stall while output is valid after each result taken, plus the long hold
    always @(negedge clk)
    begin
        if (out_fired)
        begin
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            out_wait = rx_quiet ? 0 : $urandom_range(0, 14);
        end
        out_stall <= hold_rx || (out_wait != 0);
        if (out_wait != 0 && out_valid)
            out_wait = out_wait - 1;
    end

    // long receiver hold-off, counted here so the sender keeps offering meanwhile
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_tracked();
        logic [31:0] rd;
        rd = '0;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TRACKED;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[COUNT_W-1:0] !== tracked_model)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: tracked_count readback exp %0d got %0d",
                         $realtime, tracked_model, rd[COUNT_W-1:0]);
        end
    endtask

    task automatic set_tracked(input logic [31:0] data);
        apb_write(ADDR_TRACKED, data);
        tracked_model = data[COUNT_W-1:0];
        config_writes++;
        check_tracked();
    endtask

    task automatic queue_item(input cmd_t cmd, input int idx);
        in_item_t it;
        it.command     = cmd;
        it.block_index = INDEX_W'(idx);
        pending_cmds.push_back(it);
        items_queued++;
    endtask

    // waits until every transaction is accepted and answered
    task automatic wait_drained();
        do @(negedge clk); while (items_taken != items_queued || results_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // alloc_bias out of 10 selects allocate; indices mix full range, low window, count edge
    task automatic queue_random(input int n, input int alloc_bias);
        cmd_t cmd;
        int   idx;
        int   lim;
        for (int k = 0; k < n; k++)
        begin
            lim = live_blocks();
            if ($urandom_range(0, 9) < alloc_bias)
                cmd = CMD_ALLOC;
            else
                cmd = cmd_t'(2'($urandom_range(1, 3)));
            case ($urandom_range(0, 3))
                0:       idx = $urandom_range(0, MAP_SIZE - 1);
                3:       idx = lim - 1 + $urandom_range(0, 2);
                default: idx = $urandom_range(0, (lim > 256) ? 256 : lim + 1);
            endcase
            queue_item(cmd, idx);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_tracked();

        // fresh map at full count
        queue_item(CMD_QUERY, 0);
        queue_item(CMD_ALLOC, 4095);
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_QUERY, 1);
        queue_item(CMD_MARK, 4095);
        queue_item(CMD_QUERY, 4095);
        queue_item(CMD_RELEASE, 0);
        queue_item(CMD_QUERY, 0);
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_MARK, 2);
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_RELEASE, 4095);
        queue_item(CMD_QUERY, 4095);
        queue_item(CMD_RELEASE, 1);
        queue_item(CMD_RELEASE, 1);
        queue_item(CMD_MARK, 'hAAA);
        queue_item(CMD_QUERY, 'hAAA);
        queue_item(CMD_QUERY, 'h555);
        wait_drained();

        // zero count: allocate fails, everything reads occupied, updates ignored
        set_tracked(32'h0);
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_QUERY, 0);
        queue_item(CMD_RELEASE, 0);
        queue_item(CMD_MARK, 5);
        wait_drained();

        // tiny count: last free block then nothing free, edge index out of range
        set_tracked(32'h3);
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_QUERY, 3);
        queue_item(CMD_MARK, 3);
        queue_item(CMD_RELEASE, 3);
        queue_item(CMD_QUERY, 2);
        wait_drained();

        // write to an unmapped register must leave the count alone
        apb_write(ADDR_SPARE, $urandom());
        check_tracked();

        // all ones: count above capacity saturates
        set_tracked(32'hFFFF_FFFF);
        queue_random(80, 4);
        wait_drained();

        set_tracked({$urandom_range(0, 1) ? 19'h7FFFF : 19'h0, 13'd37});
        queue_random(80, 5);
        wait_drained();

        set_tracked(32'd64);
        queue_random(80, 4);
        wait_drained();

        set_tracked(32'd1);
        queue_random(40, 4);
        wait_drained();

        set_tracked(32'd0);
        queue_random(30, 3);
        wait_drained();

        // full count with the receiver held off so the input backs up
        set_tracked(32'd4096);
        queue_random(90, 3);
        hold_go = 1'b1;
        wait_drained();

        set_tracked(32'd200);
        queue_random(80, 5);
        wait_drained();

        set_tracked(32'd4097);
        queue_random(70, 4);
        wait_drained();

        repeat (150) @(posedge clk);
        $display("Ran %0d transactions: %0d allocate (%0d granted, %0d none free), %0d release,",
                 items_taken, cmd_tally[CMD_ALLOC], grant_tally, miss_tally,
                 cmd_tally[CMD_RELEASE]);
        $display("%0d mark, %0d query, over %0d count settings incl. zero and saturated; %0d errors",
                 cmd_tally[CMD_MARK], cmd_tally[CMD_QUERY], config_writes + 1, fail_count);
        if (fail_count == 0 && results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", results_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
